### hw/rtl/min_tracking_stack_top_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the min tracking stack
// Shared property shapes that are clocked on i_clk and disabled while i_rst_n
// is low.
// ----------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_TOP_MACROS_SVH
`define MIN_TRACKING_STACK_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Constants and codes shared by the min tracking stack and its checker.
// ----------------------------------------------------------------------------
package mts_pkg;

    // Default number of entries the stack holds.
    localparam int STACK_DEPTH = 64;

    // Width of a stored value and of a stored running minimum.
    localparam int DATA_W = 32;

    // Minimum reported for an empty stack (largest signed 32-bit value).
    localparam logic signed [DATA_W-1:0] MIN_EMPTY = 32'sh7FFF_FFFF;

    // Operation codes of an input item.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // Status codes of a result item.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

endpackage

### hw/rtl/min_tracking_stack_top.sv
// ----------------------------------------------------------------------------
// min_tracking_stack_top
// LIFO stack of signed 32-bit values that also reports the minimum of all
// stored values. Each entry keeps its value and the running minimum up to it.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake           Payload
//   -------  ---------  ------------------  -----------------------------------
//   input    in         i_valid / o_stall   i_opcode, i_push_value
//   result   out        o_valid / i_stall   o_top_value, o_current_min,
//                                           o_is_empty, o_status
//
// A push, a refused push, a refused pop and a pop that empties the stack
// write their result straight into the output register. A pop that leaves
// entries behind passes through S_POP: the cached top entry has to be
// reloaded from the entry below it, and the RAM read port is registered.
// Reset clears only the entry count, the control state and the output valid
// flag; the RAM contents need no clearing because only entries below the count
// are ever read. A result waits in the output register while i_stall is high,
// and the input stalls for as long as that held result occupies the register.
// The input also stalls while a pop that reloads the top waits in S_POP.
//
module min_tracking_stack_top #(
    parameter int STACK_DEPTH = mts_pkg::STACK_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_valid,
    output logic                               o_stall,
    input  logic                               i_opcode,
    input  logic signed [mts_pkg::DATA_W-1:0]  i_push_value,

    output logic                               o_valid,
    input  logic                               i_stall,
    output logic signed [mts_pkg::DATA_W-1:0]  o_top_value,
    output logic signed [mts_pkg::DATA_W-1:0]  o_current_min,
    output logic                               o_is_empty,
    output logic [1:0]                         o_status
);

    // The count must be able to hold the depth itself; the addresses need
    // only enough bits to name an entry.
    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W = $clog2(STACK_DEPTH);
    localparam int DW     = mts_pkg::DATA_W;

    typedef enum logic {
        S_IDLE,
        S_POP
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_count, n_count;

    // Copy of the top entry, valid whenever the count is nonzero.
    logic signed [DW-1:0]  r_top_val, n_top_val;
    logic signed [DW-1:0]  r_top_min, n_top_min;

    // Output register.
    logic                  r_out_valid, n_out_valid;
    logic signed [DW-1:0]  r_out_top, n_out_top;
    logic signed [DW-1:0]  r_out_min, n_out_min;
    logic                  r_out_empty, n_out_empty;
    logic [1:0]            r_out_status, n_out_status;

    // RAM control.
    logic                  w_wr_en;
    logic                  w_rd_en;
    logic [ADDR_W-1:0]     w_wr_addr;
    logic [ADDR_W-1:0]     w_rd_addr;
    logic [CNT_W-1:0]      w_below_idx;
    logic signed [DW-1:0]  w_new_min;
    logic [DW-1:0]         w_new_min_bits;
    logic [DW-1:0]         w_rd_val;
    logic [DW-1:0]         w_rd_min;

    logic                  w_out_free;
    logic                  w_accept;
    logic                  w_full;
    logic signed [DW-1:0]  w_base_min;

    // The output register can take a new result when it is empty or when its
    // current result leaves in this cycle.
    assign w_out_free = !r_out_valid || !i_stall;
    assign o_stall    = (r_state != S_IDLE) || !w_out_free;
    assign w_accept   = i_valid && !o_stall;

    assign w_full     = (r_count == CNT_W'(STACK_DEPTH));

    // The first entry compares against the empty-stack minimum, so its
    // running minimum is its own value.
    assign w_base_min = (r_count == '0) ? mts_pkg::MIN_EMPTY : r_top_min;
    assign w_new_min  = (i_push_value < w_base_min) ? i_push_value : w_base_min;
    assign w_new_min_bits = w_new_min;

    // A push writes the slot just above the top; a pop reloads from the
    // entry just below the top.
    assign w_below_idx = r_count - CNT_W'(2);
    assign w_wr_addr   = r_count[ADDR_W-1:0];
    assign w_rd_addr   = w_below_idx[ADDR_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_top_val    = r_top_val;
        n_top_min    = r_top_min;
        n_out_valid  = r_out_valid && i_stall;
        n_out_top    = r_out_top;
        n_out_min    = r_out_min;
        n_out_empty  = r_out_empty;
        n_out_status = r_out_status;
        w_wr_en      = 1'b0;
        w_rd_en      = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_opcode)
                        mts_pkg::OP_PUSH: begin
                            n_out_valid = 1'b1;
                            if (w_full) begin
                                // Refused: report the unchanged top.
                                n_out_top    = r_top_val;
                                n_out_min    = r_top_min;
                                n_out_empty  = 1'b0;
                                n_out_status = mts_pkg::ST_FULL;
                            end else begin
                                w_wr_en      = 1'b1;
                                n_count      = r_count + CNT_W'(1);
                                n_top_val    = i_push_value;
                                n_top_min    = w_new_min;
                                n_out_top    = i_push_value;
                                n_out_min    = w_new_min;
                                n_out_empty  = 1'b0;
                                n_out_status = mts_pkg::ST_OK;
                            end
                        end
                        default: begin
                            if (r_count == '0) begin
                                n_out_valid  = 1'b1;
                                n_out_top    = '0;
                                n_out_min    = mts_pkg::MIN_EMPTY;
                                n_out_empty  = 1'b1;
                                n_out_status = mts_pkg::ST_EMPTY;
                            end else if (r_count == CNT_W'(1)) begin
                                n_count      = '0;
                                n_out_valid  = 1'b1;
                                n_out_top    = '0;
                                n_out_min    = mts_pkg::MIN_EMPTY;
                                n_out_empty  = 1'b1;
                                n_out_status = mts_pkg::ST_OK;
                            end else begin
                                // Fetch the new top; finish in S_POP once the output register is free.
                                w_rd_en = 1'b1;
                                n_state = S_POP;
                            end
                        end
                    endcase
                end
            end
            S_POP: begin
                if (w_out_free) begin
                    n_count      = r_count - CNT_W'(1);
                    n_top_val    = w_rd_val;
                    n_top_min    = w_rd_min;
                    n_out_valid  = 1'b1;
                    n_out_top    = w_rd_val;
                    n_out_min    = w_rd_min;
                    n_out_empty  = 1'b0;
                    n_out_status = mts_pkg::ST_OK;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_top_val    <= n_top_val;
        r_top_min    <= n_top_min;
        r_out_top    <= n_out_top;
        r_out_min    <= n_out_min;
        r_out_empty  <= n_out_empty;
        r_out_status <= n_out_status;
    end

    // Stored values.
    mts_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_value_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (i_push_value),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_val)
    );

    // Running minimum of each entry and everything below it.
    mts_ram #(
        .WIDTH (DW),
        .DEPTH (STACK_DEPTH)
    ) u_min_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_new_min_bits),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_min)
    );

    assign o_valid       = r_out_valid;
    assign o_top_value   = r_out_top;
    assign o_current_min = r_out_min;
    assign o_is_empty    = r_out_empty;
    assign o_status      = r_out_status;

endmodule

### hw/rtl/mts_ram.sv
// ----------------------------------------------------------------------------
// mts_ram
// Generic single-write, single-read synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module mts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        // Read data holds until the next read is issued.
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

### hw/rtl/mts_checker.sv
// ----------------------------------------------------------------------------
// mts_checker
// Port-level checks of the min tracking stack, bound to the top level.
// ----------------------------------------------------------------------------
`include "min_tracking_stack_top_macros.svh"

module mts_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_valid,
    input logic                               o_stall,
    input logic                               i_opcode,
    input logic signed [mts_pkg::DATA_W-1:0]  i_push_value,
    input logic                               o_valid,
    input logic                               i_stall,
    input logic signed [mts_pkg::DATA_W-1:0]  o_top_value,
    input logic signed [mts_pkg::DATA_W-1:0]  o_current_min,
    input logic                               o_is_empty,
    input logic [1:0]                         o_status
);

    // The running minimum can never exceed the value on top.
    `MTS_ASSERT_SAME(a_min_not_above_top, o_valid && !o_is_empty, o_current_min <= o_top_value, "minimum above top value")

    // An empty stack reports a zero top and the empty-stack minimum.
    `MTS_ASSERT_SAME(a_empty_result, o_valid && o_is_empty, (o_top_value == '0) && (o_current_min == mts_pkg::MIN_EMPTY), "bad empty result")

    // A refused push means the stack is full, a refused pop that it is empty.
    `MTS_ASSERT_SAME(a_status_vs_empty, o_valid, ((o_status != mts_pkg::ST_FULL) || !o_is_empty) && ((o_status != mts_pkg::ST_EMPTY) || o_is_empty), "status disagrees with empty flag")

    // A held result stays in place.
    `MTS_ASSERT_NEXT(a_result_holds, o_valid && i_stall, o_valid && $stable(o_top_value) && $stable(o_current_min) && $stable(o_status), "held result changed")

    // An accepted push answers in the next cycle, either refused or with the
    // pushed value on top and a minimum no larger than it.
    `MTS_ASSERT_NEXT(a_push_result, i_valid && !o_stall && (i_opcode == mts_pkg::OP_PUSH), o_valid && ((o_status == mts_pkg::ST_FULL) || ((o_top_value == $past(i_push_value)) && (o_current_min <= $past(i_push_value)))), "push result wrong")

endmodule

bind min_tracking_stack_top mts_checker u_mts_checker (.*);

### tb/tb.sv
// ----------------------------------------------------------------------------
// Min tracking stack testbench
// Sends pushes and pops to the stack through its valid/stall input channel,
// predicts the top value, running minimum, empty flag and status of every
// item, and compares each result taken from the output channel in order.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    // One result as the stack reports it after an item.
    typedef struct packed {
        logic signed [mts_pkg::DATA_W-1:0] top_value;
        logic signed [mts_pkg::DATA_W-1:0] current_min;
        logic                              is_empty;
        logic [1:0]                        status;
    } t_stack_view;

    // Shadow copy of the stack. Every accepted item is applied here in the
    // order the block takes it, and the view it leaves behind is queued
    // until the matching result arrives.
    class min_stack_scoreboard;
        logic signed [mts_pkg::DATA_W-1:0] value_mem [mts_pkg::STACK_DEPTH];
        logic signed [mts_pkg::DATA_W-1:0] floor_mem [mts_pkg::STACK_DEPTH];
        int unsigned                       held;
        t_stack_view                       expected_views [$];
        int                                mismatches;

        function logic signed [mts_pkg::DATA_W-1:0] running_min();
            return (held == 0) ? mts_pkg::MIN_EMPTY : floor_mem[held-1];
        endfunction

        function void note_item(logic op, logic signed [mts_pkg::DATA_W-1:0] val);
            t_stack_view                       view;
            logic signed [mts_pkg::DATA_W-1:0] floor_val;
            view.status = mts_pkg::ST_OK;
            if (op == mts_pkg::OP_PUSH) begin
                if (held >= mts_pkg::STACK_DEPTH) begin
                    view.status = mts_pkg::ST_FULL;
                end else begin
                    // The first entry compares against the empty minimum,
                    // so it always takes its own value.
                    floor_val = running_min();
                    if (val < floor_val) begin
                        floor_val = val;
                    end
                    value_mem[held] = val;
                    floor_mem[held] = floor_val;
                    held++;
                end
            end else if (held == 0) begin
                view.status = mts_pkg::ST_EMPTY;
            end else begin
                held--;
            end
            if (held == 0) begin
                view.top_value   = '0;
                view.current_min = mts_pkg::MIN_EMPTY;
                view.is_empty    = 1'b1;
            end else begin
                view.top_value   = value_mem[held-1];
                view.current_min = floor_mem[held-1];
                view.is_empty    = 1'b0;
            end
            expected_views.insert(expected_views.size(), view);
        endfunction

        function void check_result(t_stack_view got);
            t_stack_view want;
            if (expected_views.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result with no item pending: top %0d min %0d empty %0b st %0d",
                             $realtime, got.top_value, got.current_min, got.is_empty,
                             got.status);
                end
                return;
            end
            want = expected_views.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: expected top %0d min %0d empty %0b st %0d",
                             $realtime, want.top_value, want.current_min, want.is_empty,
                             want.status);
                    $display("%0t:   actual top %0d min %0d empty %0b st %0d",
                             $realtime, got.top_value, got.current_min, got.is_empty,
                             got.status);
                end
            end
        endfunction
    endclass

    logic                              i_clk = 1'b0;
    logic                              i_rst_n = 1'b0;
    logic                              i_valid = 1'b0;
    logic                              o_stall;
    logic                              i_opcode = mts_pkg::OP_PUSH;
    logic signed [mts_pkg::DATA_W-1:0] i_push_value = '0;
    logic                              o_valid;
    logic                              i_stall = 1'b0;
    logic signed [mts_pkg::DATA_W-1:0] o_top_value;
    logic signed [mts_pkg::DATA_W-1:0] o_current_min;
    logic                              o_is_empty;
    logic [1:0]                        o_status;

    // Upper bounds for the per-item idle draws of the two sides. The
    // stimulus changes them from phase to phase, so some stretches run
    // back to back and others idle heavily.
    int unsigned send_gap_max = 0;
    int unsigned take_gap_max = 0;

    min_stack_scoreboard sb = new();

    always #1 i_clk = ~i_clk;

    min_tracking_stack_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_opcode      (i_opcode),
        .i_push_value  (i_push_value),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_top_value   (o_top_value),
        .o_current_min (o_current_min),
        .o_is_empty    (o_is_empty),
        .o_status      (o_status)
    );

    // Presents one item and returns at the edge that accepts it. It is always
    // entered right at a rising edge, so the only assignment to i_valid in
    // that step is the one made here. Handshake signals are read in the
    // active region just after the edge, which still shows the values the
    // block sampled at that edge.
    task automatic send_item(input logic op,
                             input logic signed [mts_pkg::DATA_W-1:0] val);
        int unsigned gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_opcode     <= op;
        i_push_value <= val;
        do @(posedge i_clk); while (o_stall);
        sb.note_item(op, val);
    endtask

    // Result side: draw a stall length for every result, hold the stall for
    // that length, then release it and take the next result.
    initial begin
        int unsigned gap;
        wait (i_rst_n === 1'b1);
        forever begin
            gap = $urandom_range(0, take_gap_max);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (o_valid !== 1'b1);
            sb.check_result('{o_top_value, o_current_min, o_is_empty, o_status});
        end
    end

    // Stimulus: a directed opening, then random phases that swing the stack
    // between empty and full so both refusals and deep minimum chains occur.
    initial begin
        int unsigned                       random_sent;
        int unsigned                       phase_len;
        int unsigned                       push_pct;
        logic                              op;
        logic signed [mts_pkg::DATA_W-1:0] val;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. It starts with a pop on the empty stack, pushes the
        // largest value first so the first minimum equals the empty minimum,
        // then drives both extremes, an equal minimum, and empties the stack
        // past its bottom again.
        send_item(mts_pkg::OP_POP,  32'sh1234_5678);
        send_item(mts_pkg::OP_PUSH, mts_pkg::MIN_EMPTY);
        send_item(mts_pkg::OP_POP,  '0);
        send_item(mts_pkg::OP_PUSH, '0);
        send_item(mts_pkg::OP_PUSH, 32'sh8000_0000);
        send_item(mts_pkg::OP_PUSH, mts_pkg::MIN_EMPTY);
        send_item(mts_pkg::OP_PUSH, -32'sd1);
        send_item(mts_pkg::OP_PUSH, 32'sh8000_0000);
        send_item(mts_pkg::OP_PUSH, 32'sh5555_5555);
        send_item(mts_pkg::OP_PUSH, 32'shAAAA_AAAA);
        repeat (8) send_item(mts_pkg::OP_POP, '1);
        send_item(mts_pkg::OP_PUSH, 32'sd7);
        send_item(mts_pkg::OP_PUSH, 32'sd3);
        send_item(mts_pkg::OP_PUSH, 32'sd5);
        send_item(mts_pkg::OP_POP,  '0);
        send_item(mts_pkg::OP_POP,  '0);
        send_item(mts_pkg::OP_POP,  '0);

        // Random part. Each phase picks a push ratio and idle bounds; the
        // all-push phases can run long enough to reach a full stack.
        random_sent = 0;
        while (random_sent < 1650) begin
            phase_len = $urandom_range(8, 90);
            case ($urandom_range(0, 4))
                0:       push_pct = 100;
                1:       push_pct = 85;
                2:       push_pct = 50;
                3:       push_pct = 15;
                default: push_pct = 0;
            endcase
            case ($urandom_range(0, 2))
                0:       send_gap_max = 0;
                1:       send_gap_max = 3;
                default: send_gap_max = 16;
            endcase
            case ($urandom_range(0, 2))
                0:       take_gap_max = 0;
                1:       take_gap_max = 3;
                default: take_gap_max = 16;
            endcase
            repeat (phase_len) begin
                op = ($urandom_range(0, 99) < push_pct) ? mts_pkg::OP_PUSH : mts_pkg::OP_POP;
                case ($urandom_range(0, 7))
                    0:       val = 32'sh8000_0000;
                    1:       val = mts_pkg::MIN_EMPTY;
                    2:       val = $signed($urandom_range(0, 16)) - 8;
                    3:       val = sb.running_min();
                    default: val = $urandom;
                endcase
                send_item(op, val);
                random_sent++;
            end
        end
        i_valid <= 1'b0;

        // Drain: every queued view must be matched; the watchdog covers a
        // block that never answers. A wait after the drain catches stray results.
        while (sb.expected_views.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.expected_views.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of the item count above.
    initial begin
        #1_400_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### min_tracking_stack_top.f
+incdir+hw/rtl
hw/rtl/mts_pkg.sv
hw/rtl/mts_ram.sv
hw/rtl/min_tracking_stack_top.sv
hw/rtl/mts_checker.sv
tb/tb.sv
